### rtl/core/egcd_pkg.sv
package egcd_pkg;
    localparam int DEF_WIDTH = 64;
    localparam int DATA_W    = 63;
    localparam int COEF_W    = 64;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic div_start;
        logic div_step;
        logic mul_start;
        logic mul_step;
        logic update;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic cur_zero;
        logic div_last;
        logic mul_last;
    } t_stat;
endpackage

### rtl/core/egcd_datapath.sv
module egcd_datapath
    import egcd_pkg::*;
#(
    parameter int WIDTH = DEF_WIDTH
) (
    input  logic                i_clk,
    input  t_cmd                i_cmd,
    input  logic [DATA_W-1:0]   i_a,
    input  logic [DATA_W-1:0]   i_b,
    output t_stat               o_stat,
    output logic [DATA_W-1:0]   o_divisor,
    output logic [COEF_W-1:0]   o_coef_x,
    output logic [COEF_W-1:0]   o_coef_y
);
    localparam int OW  = WIDTH - 1;
    localparam int CW  = $clog2(OW + 1);

    logic [OW-1:0]     r_prev_r, r_cur_r, r_quo, r_rem, r_mq;
    logic [COEF_W-1:0] r_prev_sa, r_cur_sa, r_prev_sb, r_cur_sb;
    logic [COEF_W-1:0] r_pa, r_pb;
    logic [CW-1:0]     r_cnt;
    logic [OW:0]       n_trial;
    logic [OW-1:0]     n_rem_sh;

    // restoring division: one quotient bit per step
    assign n_rem_sh = {r_rem[OW-2:0], r_quo[OW-1]};
    assign n_trial  = {r_rem, r_quo[OW-1]} - {1'b0, r_cur_r};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_prev_r  <= i_b[OW-1:0];
            r_cur_r   <= i_a[OW-1:0];
            r_prev_sb <= COEF_W'(1);
            r_cur_sb  <= '0;
            r_prev_sa <= '0;
            r_cur_sa  <= COEF_W'(1);
        end
        if (i_cmd.div_start) begin
            r_quo <= r_prev_r;
            r_rem <= '0;
            r_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_cnt <= r_cnt + 1'b1;
            if (!n_trial[OW]) begin
                r_rem <= n_trial[OW-1:0];
                r_quo <= {r_quo[OW-2:0], 1'b1};
            end else begin
                r_rem <= n_rem_sh;
                r_quo <= {r_quo[OW-2:0], 1'b0};
            end
        end
        // shift-add multiply of quotient by both current coefficients
        if (i_cmd.mul_start) begin
            r_mq  <= r_quo;
            r_pa  <= '0;
            r_pb  <= '0;
            r_cnt <= '0;
        end
        if (i_cmd.mul_step) begin
            r_cnt <= r_cnt + 1'b1;
            r_mq  <= {r_mq[OW-2:0], 1'b0};
            r_pa  <= {r_pa[COEF_W-2:0], 1'b0} + (r_mq[OW-1] ? r_cur_sa : '0);
            r_pb  <= {r_pb[COEF_W-2:0], 1'b0} + (r_mq[OW-1] ? r_cur_sb : '0);
        end
        if (i_cmd.update) begin
            r_prev_r  <= r_cur_r;
            r_cur_r   <= r_rem;
            r_prev_sa <= r_cur_sa;
            r_cur_sa  <= r_prev_sa - r_pa;
            r_prev_sb <= r_cur_sb;
            r_cur_sb  <= r_prev_sb - r_pb;
        end
    end

    assign o_stat.cur_zero = (r_cur_r == '0);
    assign o_stat.div_last = (r_cnt == CW'(OW - 1));
    assign o_stat.mul_last = (r_cnt == CW'(OW - 1));
    assign o_divisor = DATA_W'(r_prev_r);
    assign o_coef_x  = r_prev_sa;
    assign o_coef_y  = r_prev_sb;
endmodule

### rtl/core/egcd_ctrl.sv
module egcd_ctrl
    import egcd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_fire,
    input  logic  i_out_free,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy,
    output logic  o_done
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_TEST = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_UPD  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;
    localparam logic [2:0] S_MST  = 3'd6;

    logic [2:0] r_state, n_state;

    // next state and command decode
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_done  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_fire) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_TEST;
                end
            end
            S_TEST: begin
                if (i_stat.cur_zero) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_MST;
                end
            end
            // quotient is complete here, load it into the multiplier
            S_MST: begin
                o_cmd.mul_start = 1'b1;
                n_state         = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                if (i_stat.mul_last) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                o_cmd.update = 1'b1;
                n_state      = S_TEST;
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_busy |-> !o_cmd.load) else $error("load while busy");
    a_one_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.mul_step && o_cmd.update)) else $error("mul and update overlap");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> r_state == S_IDLE) else $error("done did not return idle");
endmodule

### rtl/core/extended_gcd.sv
// Extended Euclid unit: takes operand_a and operand_b (WIDTH-1 bits each) and
// returns the gcd with Bezout coefficients x, y so that a*x + b*y = gcd; a zero
// operand_a gives gcd = operand_b, x = 0, y = 1. One item is in work at a time.
// Each Euclid step runs through a test state, a bit-serial restoring divide,
// a multiply start state, a bit-serial multiply of the quotient into both
// coefficients and an update state. The result is copied into an output
// register once that register is free; a new item is taken as soon as the
// result has been copied, while it may still wait in that register.
module extended_gcd
    import egcd_pkg::*;
#(
    parameter int WIDTH = DEF_WIDTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,  // operand_a [62:0], operand_b [125:63]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [191:0] m_axis_tdata   // divisor [62:0], coef_x [126:63], coef_y [190:127]
);
    t_cmd              w_cmd;
    t_stat             w_stat;
    logic              w_busy, w_done, w_in_fire, w_out_free;
    logic [DATA_W-1:0] w_a, w_b, w_div;
    logic [COEF_W-1:0] w_cx, w_cy;
    logic              r_ovalid;
    logic [191:0]      r_odata;

    assign w_a        = s_axis_tdata[62:0] & DATA_W'((65'd1 << (WIDTH - 1)) - 1);
    assign w_b        = s_axis_tdata[125:63] & DATA_W'((65'd1 << (WIDTH - 1)) - 1);
    assign s_axis_tready = !w_busy;
    assign w_in_fire  = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_ovalid || m_axis_tready;

    egcd_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_fire(w_in_fire),
        .i_out_free(w_out_free), .i_stat(w_stat), .o_cmd(w_cmd),
        .o_busy(w_busy), .o_done(w_done)
    );

    egcd_datapath #(.WIDTH(WIDTH)) u_dp (
        .i_clk(i_clk), .i_cmd(w_cmd), .i_a(w_a), .i_b(w_b), .o_stat(w_stat),
        .o_divisor(w_div), .o_coef_x(w_cx), .o_coef_y(w_cy)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_done) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_odata <= {1'b0, w_cy, w_cx, w_div};
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
endmodule
